>>> rtl/core/rlc_pkg.sv
// Shared types and constants of the line clipper.
`default_nettype none

package rlc_pkg;

    // Outcode bits
    localparam logic [3:0] OC_LEFT   = 4'b0001;
    localparam logic [3:0] OC_BOTTOM = 4'b0010;
    localparam logic [3:0] OC_RIGHT  = 4'b0100;
    localparam logic [3:0] OC_TOP    = 4'b1000;

    // Moves allowed per segment
    localparam logic [2:0] MAX_MOVES = 3'd4;

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_WIN_LEFT   = 2'd0;
    localparam logic [1:0] REG_WIN_BOTTOM = 2'd1;
    localparam logic [1:0] REG_WIN_RIGHT  = 2'd2;
    localparam logic [1:0] REG_WIN_TOP    = 2'd3;

    // Window reset values
    localparam int WIN_LEFT_RST   = 0;
    localparam int WIN_BOTTOM_RST = 0;
    localparam int WIN_RIGHT_RST  = 1023;
    localparam int WIN_TOP_RST    = 767;

    // Controller states
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EVAL = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_DIVS = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_UPD  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic mult;
        logic div_start;
        logic update;
        logic out_load;
        logic out_rej;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic code_any;
        logic code_share;
        logic div_done;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/core/rlc_if.sv
// Valid/ready channel interfaces for segment input and clipped output.
`default_nettype none

interface rlc_in_if #(
    parameter int COORD_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [COORD_WIDTH-1:0]  ax_in;
    logic signed [COORD_WIDTH-1:0]  ay_in;
    logic signed [COORD_WIDTH-1:0]  bx_in;
    logic signed [COORD_WIDTH-1:0]  by_in;

    modport source (output valid, ax_in, ay_in, bx_in, by_in, input ready);
    modport sink   (input valid, ax_in, ay_in, bx_in, by_in, output ready);
endinterface

interface rlc_out_if #(
    parameter int COORD_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [COORD_WIDTH-1:0]  ax_out;
    logic signed [COORD_WIDTH-1:0]  ay_out;
    logic signed [COORD_WIDTH-1:0]  bx_out;
    logic signed [COORD_WIDTH-1:0]  by_out;
    logic                           rejected;

    modport source (output valid, ax_out, ay_out, bx_out, by_out, rejected, input ready);
    modport sink   (input valid, ax_out, ay_out, bx_out, by_out, rejected, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rlc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module rlc_div #(
    parameter int NW = 33,
    parameter int DW = 17,
    parameter int QW = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [NW-1:0]  i_num,
    input  wire logic [DW-1:0]  i_den,
    output logic                o_done,
    output logic [QW-1:0]       o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic            r_busy;
    logic [CW-1:0]   r_cnt;
    logic [DW-1:0]   r_rem;
    logic [NW-1:0]   r_quo;
    logic [DW-1:0]   r_den;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            fits;

    // Shift in the next numerator bit and try the subtract
    always_comb begin
        trial = {r_rem, r_quo[NW-1]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
    end

    assign o_done = r_busy && (r_cnt == CW'(NW - 1));
    assign o_quo  = r_quo[QW-1:0];

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (o_done) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
            r_quo <= {r_quo[NW-2:0], fits};
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rlc_dp.sv
// Clipper datapath: endpoints, outcodes, interpolation and output register.
`default_nettype none

module rlc_dp #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rlc_pkg::t_cmd                 i_cmd,
    output rlc_pkg::t_sts                      o_sts,
    input  wire logic signed [COORD_WIDTH-1:0] i_win_left,
    input  wire logic signed [COORD_WIDTH-1:0] i_win_bottom,
    input  wire logic signed [COORD_WIDTH-1:0] i_win_right,
    input  wire logic signed [COORD_WIDTH-1:0] i_win_top,
    input  wire logic signed [COORD_WIDTH-1:0] i_ax,
    input  wire logic signed [COORD_WIDTH-1:0] i_ay,
    input  wire logic signed [COORD_WIDTH-1:0] i_bx,
    input  wire logic signed [COORD_WIDTH-1:0] i_by,
    output logic signed [COORD_WIDTH-1:0]      o_ax,
    output logic signed [COORD_WIDTH-1:0]      o_ay,
    output logic signed [COORD_WIDTH-1:0]      o_bx,
    output logic signed [COORD_WIDTH-1:0]      o_by,
    output logic                               o_rej
);
    import rlc_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int NW = 2 * W + 1;
    localparam int DW = W + 1;

    // Segment held on entry, and the working endpoints
    logic signed [W-1:0] r_ax_in, r_ay_in, r_bx_in, r_by_in;
    logic signed [W-1:0] r_x1, r_y1, r_x2, r_y2;

    // Interpolation operands
    logic                r_sel_b;
    logic                r_edge_x;
    logic signed [W-1:0] r_e;
    logic signed [W-1:0] r_p0;
    logic signed [W:0]   r_dq, r_de, r_den;
    logic signed [2*W+1:0] r_prod;
    logic                r_neg;
    logic                r_den_zero;

    logic [3:0]          c1, c2, csel;
    logic                edge_x;
    logic signed [W-1:0] e_val;
    logic signed [W-1:0] p0_val;
    logic signed [W:0]   dq_val, de_val, den_val;
    logic signed [W:0]   x1_s, y1_s, x2_s, y2_s, e_s;
    logic [NW-1:0]       num_abs;
    logic [DW-1:0]       den_abs;
    logic                div_done;
    logic [W-1:0]        quo_mag;
    logic signed [W-1:0] quo_val;
    logic signed [W-1:0] interp_val;
    logic signed [W-1:0] new_x, new_y;

    function automatic logic [3:0] f_outcode(
        input logic signed [W-1:0] x,
        input logic signed [W-1:0] y,
        input logic signed [W-1:0] wl,
        input logic signed [W-1:0] wb,
        input logic signed [W-1:0] wr,
        input logic signed [W-1:0] wt
    );
        logic [3:0] c;
        c = '0;
        if (x < wl) begin
            c = OC_LEFT;
        end else if (x > wr) begin
            c = OC_RIGHT;
        end
        if (y < wb) begin
            c = c | OC_BOTTOM;
        end else if (y > wt) begin
            c = c | OC_TOP;
        end
        return c;
    endfunction

    // Outcodes of the current endpoints
    always_comb begin
        c1 = f_outcode(r_x1, r_y1, i_win_left, i_win_bottom, i_win_right, i_win_top);
        c2 = f_outcode(r_x2, r_y2, i_win_left, i_win_bottom, i_win_right, i_win_top);
        o_sts.code_any   = ((c1 | c2) != 4'b0000);
        o_sts.code_share = ((c1 & c2) != 4'b0000);
        o_sts.div_done   = div_done;
    end

    // Edge choice and interpolation operands; endpoint one is always the base
    always_comb begin
        csel = (c1 != 4'b0000) ? c1 : c2;
        x1_s = {r_x1[W-1], r_x1};
        y1_s = {r_y1[W-1], r_y1};
        x2_s = {r_x2[W-1], r_x2};
        y2_s = {r_y2[W-1], r_y2};
        if ((csel & OC_LEFT) != 4'b0000) begin
            edge_x = 1'b1;
            e_val  = i_win_left;
        end else if ((csel & OC_RIGHT) != 4'b0000) begin
            edge_x = 1'b1;
            e_val  = i_win_right;
        end else if ((csel & OC_BOTTOM) != 4'b0000) begin
            edge_x = 1'b0;
            e_val  = i_win_bottom;
        end else begin
            edge_x = 1'b0;
            e_val  = i_win_top;
        end
        e_s = {e_val[W-1], e_val};
        if (edge_x) begin
            p0_val  = r_y1;
            dq_val  = y2_s - y1_s;
            de_val  = e_s - x1_s;
            den_val = x2_s - x1_s;
        end else begin
            p0_val  = r_x1;
            dq_val  = x2_s - x1_s;
            de_val  = e_s - y1_s;
            den_val = y2_s - y1_s;
        end
    end

    // Magnitudes for the divider
    always_comb begin
        num_abs = NW'(r_prod[2*W+1] ? -r_prod : r_prod);
        den_abs = DW'(r_den[W] ? -r_den : r_den);
    end

    rlc_div #(
        .NW (NW),
        .DW (DW),
        .QW (W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num_abs),
        .i_den   (den_abs),
        .o_done  (div_done),
        .o_quo   (quo_mag)
    );

    // Signed quotient, zero on a zero divisor, then the new point
    always_comb begin
        if (r_den_zero) begin
            quo_val = '0;
        end else if (r_neg) begin
            quo_val = -$signed(quo_mag);
        end else begin
            quo_val = $signed(quo_mag);
        end
        interp_val = r_p0 + quo_val;
        if (r_edge_x) begin
            new_x = r_e;
            new_y = interp_val;
        end else begin
            new_x = interp_val;
            new_y = r_e;
        end
    end

    // Endpoint registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax_in <= i_ax;
            r_ay_in <= i_ay;
            r_bx_in <= i_bx;
            r_by_in <= i_by;
            r_x1    <= i_ax;
            r_y1    <= i_ay;
            r_x2    <= i_bx;
            r_y2    <= i_by;
        end else if (i_cmd.update) begin
            if (r_sel_b) begin
                r_x2 <= new_x;
                r_y2 <= new_y;
            end else begin
                r_x1 <= new_x;
                r_y1 <= new_y;
            end
        end
    end

    // Operand, product and sign registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_sel_b    <= (c1 == 4'b0000);
            r_edge_x   <= edge_x;
            r_e        <= e_val;
            r_p0       <= p0_val;
            r_dq       <= dq_val;
            r_de       <= de_val;
            r_den      <= den_val;
            r_den_zero <= (den_val == '0);
        end
        if (i_cmd.mult) begin
            r_prod <= r_dq * r_de;
        end
        if (i_cmd.div_start) begin
            r_neg <= r_prod[2*W+1] ^ r_den[W];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_rej <= i_cmd.out_rej;
            if (i_cmd.out_rej) begin
                o_ax <= r_ax_in;
                o_ay <= r_ay_in;
                o_bx <= r_bx_in;
                o_by <= r_by_in;
            end else begin
                o_ax <= r_x1;
                o_ay <= r_y1;
                o_bx <= r_x2;
                o_by <= r_y2;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rlc_ctrl.sv
// Clipper controller: sequences loads, moves, divisions and output beats.
`default_nettype none

module rlc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire rlc_pkg::t_sts i_sts,
    output rlc_pkg::t_cmd      o_cmd
);
    import rlc_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_moves, n_moves;
    logic       r_rej, n_rej;
    logic       r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_moves     = r_moves;
        n_rej       = r_rej;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.out_rej = r_rej;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_moves    = '0;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!i_sts.code_any) begin
                    n_rej   = 1'b0;
                    n_state = S_DONE;
                end else if (i_sts.code_share) begin
                    n_rej   = 1'b1;
                    n_state = S_DONE;
                end else if (r_moves == MAX_MOVES) begin
                    n_rej   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.setup = 1'b1;
                    n_moves     = r_moves + 1'b1;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mult = 1'b1;
                n_state    = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_EVAL;
            end
            S_DONE: begin
                // Wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_moves     <= '0;
            r_rej       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_moves     <= n_moves;
            r_rej       <= n_rej;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rect_line_clipper.sv
// Top level of the line clipper: register port, controller and datapath.
//
//  channel   dir  handshake        beat contents
//  i_line    in   valid/ready      ax_in, ay_in, bx_in, by_in
//  o_line    out  valid/ready      ax_out, ay_out, bx_out, by_out, rejected
//  APB       in   psel/penable     window registers at 0x0, 0x4, 0x8, 0xC
//
// One segment at a time. Accept, outcode evaluation, then per move (at most
// four) the set-up, multiply, divider load, serial division at one quotient
// bit per cycle, and endpoint update; after the last evaluation the result
// goes to the output register.
// Reset is synchronous and active low; the window returns to 0,0..1023,767.
// A stalled output beat holds; the next segment is taken while it waits.
`default_nettype none

module rect_line_clipper #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rlc_in_if.sink           i_line,
    rlc_out_if.source        o_line,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rlc_pkg::*;

    localparam int W = COORD_WIDTH;

    logic signed [W-1:0] r_win_left, r_win_bottom, r_win_right, r_win_top;
    logic                wr_en;
    logic signed [W-1:0] rd_reg;
    t_cmd                cmd;
    t_sts                sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Window register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= W'(WIN_LEFT_RST);
            r_win_bottom <= W'(WIN_BOTTOM_RST);
            r_win_right  <= W'(WIN_RIGHT_RST);
            r_win_top    <= W'(WIN_TOP_RST);
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_WIN_LEFT:   r_win_left   <= pwdata[W-1:0];
                REG_WIN_BOTTOM: r_win_bottom <= pwdata[W-1:0];
                REG_WIN_RIGHT:  r_win_right  <= pwdata[W-1:0];
                REG_WIN_TOP:    r_win_top    <= pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    // Read back, sign extended
    always_comb begin
        unique case (paddr[3:2])
            REG_WIN_LEFT:   rd_reg = r_win_left;
            REG_WIN_BOTTOM: rd_reg = r_win_bottom;
            REG_WIN_RIGHT:  rd_reg = r_win_right;
            REG_WIN_TOP:    rd_reg = r_win_top;
            default:        rd_reg = '0;
        endcase
        prdata = {{(32-W){rd_reg[W-1]}}, rd_reg};
    end

    rlc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_line.valid),
        .o_in_ready  (i_line.ready),
        .o_out_valid (o_line.valid),
        .i_out_ready (o_line.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rlc_dp #(
        .COORD_WIDTH (W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_win_left   (r_win_left),
        .i_win_bottom (r_win_bottom),
        .i_win_right  (r_win_right),
        .i_win_top    (r_win_top),
        .i_ax         (i_line.ax_in),
        .i_ay         (i_line.ay_in),
        .i_bx         (i_line.bx_in),
        .i_by         (i_line.by_in),
        .o_ax         (o_line.ax_out),
        .o_ay         (o_line.ay_out),
        .o_bx         (o_line.bx_out),
        .o_by         (o_line.by_out),
        .o_rej        (o_line.rejected)
    );

endmodule

`default_nettype wire

>>> dv/tb_rect_line_clipper.sv
// Self-checking testbench for the line clipper: APB window set-up, directed and random segments, scoreboard.
`default_nettype none

module tb_rect_line_clipper;
    import rlc_pkg::*;

    localparam int CW          = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 160;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 145;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
    } t_seg;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic                 rejected;
    } t_clip;

    // Predicts the clipped segment for each accepted beat and checks the output beats
    class clip_scoreboard;
        int    win_left;
        int    win_bottom;
        int    win_right;
        int    win_top;
        t_clip expected_q[$];
        int    n_checked;
        int    n_rejected;
        int    n_mismatch;

        function new();
            win_left   = WIN_LEFT_RST;
            win_bottom = WIN_BOTTOM_RST;
            win_right  = WIN_RIGHT_RST;
            win_top    = WIN_TOP_RST;
            n_checked  = 0;
            n_rejected = 0;
            n_mismatch = 0;
        endfunction

        function void set_window(logic [1:0] idx, int val);
            case (idx)
                REG_WIN_LEFT:   win_left   = val;
                REG_WIN_BOTTOM: win_bottom = val;
                REG_WIN_RIGHT:  win_right  = val;
                REG_WIN_TOP:    win_top    = val;
                default: ;
            endcase
        endfunction

        // Left excludes right, below excludes above
        function logic [3:0] region_code(longint x, longint y);
            logic [3:0] c;
            c = 4'b0000;
            if (x < win_left)
                c = OC_LEFT;
            else if (x > win_right)
                c = OC_RIGHT;
            if (y < win_bottom)
                c = c | OC_BOTTOM;
            else if (y > win_top)
                c = c | OC_TOP;
            return c;
        endfunction

        // p0 + (q1 - q0) * (e - r0) / (r1 - r0), division truncating toward zero
        function longint lerp_edge(longint p0, longint q0, longint q1,
                                   longint r0, longint r1, longint e);
            longint den;
            longint num;
            den = r1 - r0;
            num = (q1 - q0) * (e - r0);
            if (den == 0)
                return p0;
            return p0 + num / den;
        endfunction

        function t_clip clip_segment(t_seg s);
            longint     x1, y1, x2, y2, x, y;
            logic [3:0] c1, c2, c;
            bit         rej;
            int         moves;
            t_clip      r;
            x1 = longint'(s.ax);
            y1 = longint'(s.ay);
            x2 = longint'(s.bx);
            y2 = longint'(s.by);
            c1 = region_code(x1, y1);
            c2 = region_code(x2, y2);
            rej = 1'b0;
            moves = 0;
            while ((c1 | c2) != 4'b0000) begin
                if ((c1 & c2) != 4'b0000) begin
                    rej = 1'b1;
                    break;
                end
                if (moves >= int'(MAX_MOVES))
                    break;
                moves++;
                c = (c1 != 4'b0000) ? c1 : c2;
                if ((c & OC_LEFT) != 4'b0000) begin
                    x = win_left;
                    y = lerp_edge(y1, y1, y2, x1, x2, win_left);
                end else if ((c & OC_RIGHT) != 4'b0000) begin
                    x = win_right;
                    y = lerp_edge(y1, y1, y2, x1, x2, win_right);
                end else if ((c & OC_BOTTOM) != 4'b0000) begin
                    y = win_bottom;
                    x = lerp_edge(x1, x1, x2, y1, y2, win_bottom);
                end else begin
                    y = win_top;
                    x = lerp_edge(x1, x1, x2, y1, y2, win_top);
                end
                if (c1 != 4'b0000) begin
                    x1 = x;
                    y1 = y;
                    c1 = region_code(x, y);
                end else begin
                    x2 = x;
                    y2 = y;
                    c2 = region_code(x, y);
                end
            end
            if (rej) begin
                r.ax = s.ax;
                r.ay = s.ay;
                r.bx = s.bx;
                r.by = s.by;
            end else begin
                r.ax = x1[CW-1:0];
                r.ay = y1[CW-1:0];
                r.bx = x2[CW-1:0];
                r.by = y2[CW-1:0];
            end
            r.rejected = rej;
            return r;
        endfunction

        function void note_segment(t_seg s);
            expected_q.push_back(clip_segment(s));
        endfunction

        function void flag(string what, longint e, longint a);
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("mismatch at result %0d on %s: expected %0d, got %0d",
                         n_checked, what, e, a);
        endfunction

        function void check_result(t_clip got);
            t_clip exp;
            if (expected_q.size() == 0) begin
                flag("unexpected output beat", 0, 0);
                return;
            end
            exp = expected_q.pop_front();
            if (got.ax !== exp.ax)
                flag("ax_out", longint'(exp.ax), longint'(got.ax));
            if (got.ay !== exp.ay)
                flag("ay_out", longint'(exp.ay), longint'(got.ay));
            if (got.bx !== exp.bx)
                flag("bx_out", longint'(exp.bx), longint'(got.bx));
            if (got.by !== exp.by)
                flag("by_out", longint'(exp.by), longint'(got.by));
            if (got.rejected !== exp.rejected)
                flag("rejected", longint'(exp.rejected), longint'(got.rejected));
            if (exp.rejected)
                n_rejected++;
            n_checked++;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int             cycle_count = 0;
    int             n_windows   = 0;
    bit             steady      = 1'b0;
    int             win_cur[4];
    clip_scoreboard sb          = new();

    rlc_in_if  #(.COORD_WIDTH(CW)) line_in ();
    rlc_out_if #(.COORD_WIDTH(CW)) line_out ();

    rect_line_clipper #(.COORD_WIDTH(CW)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (line_in),
        .o_line  (line_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock, period 4
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.expected_q.size());
            $display("rect_line_clipper test failed");
            $finish;
        end
    end

    // Known values on every input from time zero
    initial begin
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        line_in.valid <= 1'b0;
        line_in.ax_in <= '0;
        line_in.ay_in <= '0;
        line_in.bx_in <= '0;
        line_in.by_in <= '0;
        line_out.ready <= 1'b0;
    end

    // Output side: random stall before each beat (none while steady), then check it
    initial begin
        int    stall;
        t_clip got;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                line_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            line_out.ready <= 1'b1;
            do @(posedge i_clk); while (line_out.valid !== 1'b1);
            got.ax       = line_out.ax_out;
            got.ay       = line_out.ay_out;
            got.bx       = line_out.bx_out;
            got.by       = line_out.by_out;
            got.rejected = line_out.rejected;
            sb.check_result(got);
        end
    end

    // One input beat, after a random gap (no gap while steady)
    task automatic drive_segment(int ax, int ay, int bx, int by);
        int   gap;
        t_seg s;
        s.ax = ax[CW-1:0];
        s.ay = ay[CW-1:0];
        s.bx = bx[CW-1:0];
        s.by = by[CW-1:0];
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            line_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        line_in.valid <= 1'b1;
        line_in.ax_in <= s.ax;
        line_in.ay_in <= s.ay;
        line_in.bx_in <= s.bx;
        line_in.by_in <= s.by;
        do @(posedge i_clk); while (line_in.ready !== 1'b1);
        sb.note_segment(s);
    endtask

    task automatic wait_drained();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    // One APB access, a write or a read; a read compares the low bits
    task automatic apb_access(logic [1:0] idx, bit wr, int val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (!wr && prdata[CW-1:0] !== val[CW-1:0])
            sb.flag("register read-back", longint'(val),
                    longint'($signed(prdata[CW-1:0])));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Block must be idle: input side quiet and every result returned
    task automatic program_window(int l, int b, int r, int t);
        int vals[4];
        vals = '{l, b, r, t};
        line_in.valid <= 1'b0;
        wait_drained();
        for (int i = 0; i < 4; i++) begin
            apb_access(2'(i), 1'b1, vals[i]);
            sb.set_window(2'(i), vals[i]);
            win_cur[i] = vals[i];
        end
        for (int i = 0; i < 4; i++)
            apb_access(2'(i), 1'b0, vals[i]);
        n_windows++;
    endtask

    function automatic int clamp_coord(int v);
        if (v < -32768)
            return -32768;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    // Coordinate biased towards the window on one axis
    function automatic int pick_coord(int lo, int hi);
        int a, b, v;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        case ($urandom_range(0, 9))
            0, 1:       v = int'($signed(16'($urandom())));
            2, 3, 4, 5: v = a + int'($urandom_range(0, b - a));
            6:          v = lo + int'($urandom_range(0, 8)) - 4;
            7:          v = hi + int'($urandom_range(0, 8)) - 4;
            8: begin
                case ($urandom_range(0, 3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            default: begin
                if ($urandom_range(0, 1) == 0)
                    v = a - int'($urandom_range(1, 4000));
                else
                    v = b + int'($urandom_range(1, 4000));
            end
        endcase
        return clamp_coord(v);
    endfunction

    function automatic int rand_coord();
        return int'($signed(16'($urandom())));
    endfunction

    initial begin
        int l, b, r, t;
        win_cur = '{WIN_LEFT_RST, WIN_BOTTOM_RST, WIN_RIGHT_RST, WIN_TOP_RST};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset window 0..1023 x 0..767
        drive_segment(0, 0, 1023, 767);
        drive_segment(-5, 10, -1, 500);
        drive_segment(-100, 100, 500, 200);
        drive_segment(500, 100, 2000, 300);
        drive_segment(100, -50, 200, 300);
        drive_segment(100, 100, 300, 1000);
        drive_segment(500, 500, -300, 400);
        drive_segment(-32768, -32768, 32767, 32767);
        drive_segment(-32768, 32767, 32767, -32768);
        drive_segment(32767, 32767, 32767, -32768);
        drive_segment(-10, -10, -10, -10);
        drive_segment(-100, 700, 100, 900);
        // the moved point lands below the window
        drive_segment(-3, 1, 1, -2);
        drive_segment(-10, -10, 10, 10);
        drive_segment(-32768, 0, 32767, 1);

        // Directed: inverted window on both axes
        program_window(100, 50, -100, -50);
        drive_segment(0, 0, 0, 0);
        drive_segment(-200, 0, 200, 0);
        drive_segment(0, -200, 0, 200);
        drive_segment(-32768, -32768, 32767, 32767);
        drive_segment(150, 10, -150, -10);
        drive_segment(-32768, 32767, -32768, 32767);

        // Random phases, a different window each
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: program_window(-32768, -32768, 32767, 32767);
                1: program_window(32767, 32767, 32767, 32767);
                2: program_window(-32768, -32768, -32768, -32768);
                3: program_window(-1000, -500, 1000, 500);
                4: program_window(200, 300, -200, -300);
                5: program_window(0, 0, 0, 0);
                6: program_window(WIN_LEFT_RST, WIN_BOTTOM_RST, WIN_RIGHT_RST, WIN_TOP_RST);
                default: begin
                    l = rand_coord();
                    b = rand_coord();
                    if (p == N_PHASES - 1) begin
                        // fully random, may come out inverted
                        r = rand_coord();
                        t = rand_coord();
                    end else begin
                        r = clamp_coord(l + int'($urandom_range(0, 3000)));
                        t = clamp_coord(b + int'($urandom_range(0, 3000)));
                    end
                    program_window(l, b, r, t);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 32 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                // hold the sender until the block has returned everything
                if (n == 70) begin
                    line_in.valid <= 1'b0;
                    wait_drained();
                end
                if ($urandom_range(0, 9) == 0)
                    drive_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
                else
                    drive_segment(pick_coord(win_cur[REG_WIN_LEFT], win_cur[REG_WIN_RIGHT]),
                                  pick_coord(win_cur[REG_WIN_BOTTOM], win_cur[REG_WIN_TOP]),
                                  pick_coord(win_cur[REG_WIN_LEFT], win_cur[REG_WIN_RIGHT]),
                                  pick_coord(win_cur[REG_WIN_BOTTOM], win_cur[REG_WIN_TOP]));
            end
        end
        steady = 1'b0;
        line_in.valid <= 1'b0;

        // Let the last results come back, then watch for strays
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d segments compared, %0d of them rejected, over %0d window settings",
                 sb.n_checked, sb.n_rejected, n_windows + 1);
        $display("%0d mismatches in %0d cycles", sb.n_mismatch, cycle_count);
        if (sb.n_mismatch == 0 && sb.expected_q.size() == 0)
            $display("rect_line_clipper test passed");
        else
            $display("rect_line_clipper test failed");
        $finish;
    end

endmodule

`default_nettype wire
